@@ hdl/two_level_event_queue_unit_macros.svh @@
// Assertion macros used by the event queue RTL.
// No dependencies; the asserting module must have i_clk and i_rst_n.
`ifndef TWO_LEVEL_EVENT_QUEUE_UNIT_MACROS_SVH
`define TWO_LEVEL_EVENT_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define TLQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tlq_pkg.sv @@
// Types and codes for the two-level event queue.
// No dependencies.
package tlq_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [2:0] SEL_PARENT = 3'd0;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PRD,
        S_LINK,
        S_LRD,
        S_CRD,
        S_SCAN,
        S_CHK,
        S_SHR,
        S_SHW
    } t_state;

endpackage

@@ hdl/tlq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/two_level_event_queue_unit.sv @@
//  channel  | direction | handshake                 | payload
//  request  | in        | i_start, o_busy           | i_operation, i_queue_select, i_event_data
//  result   | out       | o_result_valid (1 cycle)  | o_status, o_event_out, o_notify
//  config   | in        | i_cfg_valid, o_cfg_ready  | i_cfg_data (notify enable)
// A push, or a pop of an empty queue, ends in S_EXEC; a parent pop reads the head in S_PRD
// and, for a child link, goes on through S_LINK and S_LRD. A child pop reads its head (S_CRD),
// finds its link (S_SCAN, S_CHK) and closes up later entries (S_SHR, S_SHW) via one parent RAM port.
// Reset is synchronous active low; stores need no clearing, fill counts guard reads.
// The result strobe cannot be stalled; the next request may start in that cycle.
// Depends on tlq_pkg, tlq_ram and two_level_event_queue_unit_macros.svh.
`include "two_level_event_queue_unit_macros.svh"

module two_level_event_queue_unit #(
    parameter int NUM_CHILDREN = 4,
    parameter int CHILD_DEPTH  = 16,
    parameter int PARENT_DEPTH = 64,
    parameter int EVENT_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_operation,
    input  logic [2:0]  i_queue_select,
    input  logic [31:0] i_event_data,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_event_out,
    output logic        o_notify,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int PAW = $clog2(PARENT_DEPTH);
    localparam int PFW = $clog2(PARENT_DEPTH + 1);
    localparam int CAW = $clog2(CHILD_DEPTH);
    localparam int CFW = $clog2(CHILD_DEPTH + 1);
    localparam int CIW = (NUM_CHILDREN > 1) ? $clog2(NUM_CHILDREN) : 1;
    localparam int CMD = NUM_CHILDREN * CHILD_DEPTH;
    localparam int CMW = $clog2(CMD);
    localparam int EW  = EVENT_WIDTH + 1;

    tlq_pkg::t_state r_state, n_state;

    logic                   r_op, n_op;
    logic                   r_parent, n_parent;
    logic                   r_is_child, n_is_child;
    logic [CIW-1:0]         r_cidx, n_cidx;
    logic [EVENT_WIDTH-1:0] r_data, n_data;
    logic [PFW-1:0]         r_k, n_k;
    logic [EVENT_WIDTH-1:0] r_ev, n_ev;
    logic [CAW-1:0]         r_chead [NUM_CHILDREN];
    logic [CFW-1:0]         r_cfill [NUM_CHILDREN];
    logic [CAW-1:0]         n_chead_sel;
    logic [CFW-1:0]         n_cfill_sel;
    logic [PAW-1:0]         r_phead, n_phead;
    logic [PFW-1:0]         r_pfill, n_pfill;
    logic                   r_notify_en;
    logic                   r_valid, n_valid;
    logic [1:0]             r_status, n_status;
    logic [EVENT_WIDTH-1:0] r_evout, n_evout;
    logic                   r_nt, n_nt;

    // parent RAM
    logic                   pram_we;
    logic [EW-1:0]          pram_wdata;
    logic [EW-1:0]          pram_rdata;
    // child RAM
    logic                   cram_we;
    logic [CMW-1:0]         cram_addr;
    logic [EVENT_WIDTH-1:0] cram_rdata;

    // shared slot adders
    logic [PFW-1:0]  p_off;
    logic [PFW:0]    p_sum;
    logic [PAW-1:0]  p_slot;
    logic [CFW-1:0]  c_off;
    logic [CFW:0]    c_sum;
    logic [CAW-1:0]  c_slot;

    logic [CAW-1:0]  chead_sel;
    logic [CFW-1:0]  cfill_sel;
    logic            pfull, pempty, cfull, cempty;
    logic            scan_end, link_match, more_after;
    logic [PFW:0]    k_plus1;
    logic [PAW-1:0]  phead_inc;
    logic [CAW-1:0]  chead_inc;
    logic            in_is_child;

    assign chead_sel  = r_chead[r_cidx];
    assign cfill_sel  = r_cfill[r_cidx];
    assign pfull      = (r_pfill == PFW'(PARENT_DEPTH));
    assign pempty     = (r_pfill == '0);
    assign cfull      = (cfill_sel == CFW'(CHILD_DEPTH));
    assign cempty     = (cfill_sel == '0);
    assign scan_end   = (r_k >= r_pfill);
    assign link_match = pram_rdata[EVENT_WIDTH]
                        && (pram_rdata[CIW-1:0] == r_cidx)
                        && (pram_rdata[EVENT_WIDTH-1:0] >> CIW) == '0;
    assign k_plus1    = {1'b0, r_k} + (PFW+1)'(1);
    assign more_after = (k_plus1 < {1'b0, r_pfill});
    assign phead_inc  = (r_phead == PAW'(PARENT_DEPTH - 1)) ? '0 : r_phead + PAW'(1);
    assign chead_inc  = (chead_sel == CAW'(CHILD_DEPTH - 1)) ? '0 : chead_sel + CAW'(1);
    assign in_is_child = (32'(i_queue_select) >= 32'd1)
                         && (32'(i_queue_select) <= 32'(NUM_CHILDREN));

    // offset into the parent ring for this state
    always_comb begin
        case (r_state)
            tlq_pkg::S_EXEC: p_off = (r_op == tlq_pkg::OP_PUSH) ? r_pfill : '0;
            tlq_pkg::S_SCAN: p_off = r_k;
            tlq_pkg::S_SHR:  p_off = k_plus1[PFW-1:0];
            tlq_pkg::S_SHW:  p_off = r_k;
            default:         p_off = '0;
        endcase
    end

    assign p_sum  = {1'b0, PFW'(r_phead)} + {1'b0, p_off};
    assign p_slot = (p_sum >= (PFW+1)'(PARENT_DEPTH))
                    ? PAW'(p_sum - (PFW+1)'(PARENT_DEPTH)) : PAW'(p_sum);

    assign c_off  = (r_state == tlq_pkg::S_EXEC && r_op == tlq_pkg::OP_PUSH) ? cfill_sel : '0;
    assign c_sum  = {1'b0, CFW'(chead_sel)} + {1'b0, c_off};
    assign c_slot = (c_sum >= (CFW+1)'(CHILD_DEPTH))
                    ? CAW'(c_sum - (CFW+1)'(CHILD_DEPTH)) : CAW'(c_sum);
    assign cram_addr = CMW'(CMW'(r_cidx) * CMW'(CHILD_DEPTH)) + CMW'(c_slot);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlq_pkg::S_IDLE: if (i_start) n_state = tlq_pkg::S_EXEC;
            tlq_pkg::S_EXEC: begin
                if (r_op == tlq_pkg::OP_PUSH) begin
                    n_state = tlq_pkg::S_IDLE;
                end else if (r_parent) begin
                    n_state = pempty ? tlq_pkg::S_IDLE : tlq_pkg::S_PRD;
                end else if (r_is_child) begin
                    n_state = cempty ? tlq_pkg::S_IDLE : tlq_pkg::S_CRD;
                end else begin
                    n_state = tlq_pkg::S_IDLE;
                end
            end
            tlq_pkg::S_PRD:  n_state = pram_rdata[EVENT_WIDTH] ? tlq_pkg::S_LINK
                                                                : tlq_pkg::S_IDLE;
            tlq_pkg::S_LINK: n_state = cempty ? tlq_pkg::S_IDLE : tlq_pkg::S_LRD;
            tlq_pkg::S_LRD:  n_state = tlq_pkg::S_IDLE;
            tlq_pkg::S_CRD:  n_state = tlq_pkg::S_SCAN;
            tlq_pkg::S_SCAN: n_state = scan_end ? tlq_pkg::S_IDLE : tlq_pkg::S_CHK;
            tlq_pkg::S_CHK: begin
                if (link_match) begin
                    n_state = (r_k == '0) ? tlq_pkg::S_IDLE : tlq_pkg::S_SHR;
                end else begin
                    n_state = tlq_pkg::S_SCAN;
                end
            end
            tlq_pkg::S_SHR:  n_state = more_after ? tlq_pkg::S_SHW : tlq_pkg::S_IDLE;
            tlq_pkg::S_SHW:  n_state = tlq_pkg::S_SHR;
            default:         n_state = tlq_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op        = r_op;
        n_parent    = r_parent;
        n_is_child  = r_is_child;
        n_cidx      = r_cidx;
        n_data      = r_data;
        n_k         = r_k;
        n_ev        = r_ev;
        n_chead_sel = chead_sel;
        n_cfill_sel = cfill_sel;
        n_phead     = r_phead;
        n_pfill     = r_pfill;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_evout     = r_evout;
        n_nt        = r_nt;
        pram_we     = 1'b0;
        pram_wdata  = {1'b0, r_data};
        cram_we     = 1'b0;
        case (r_state)
            tlq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op       = i_operation;
                    n_parent   = (i_queue_select == tlq_pkg::SEL_PARENT);
                    n_is_child = in_is_child;
                    n_cidx     = in_is_child ? CIW'(32'(i_queue_select) - 32'd1) : '0;
                    n_data     = i_event_data[EVENT_WIDTH-1:0];
                    n_k        = '0;
                end
            end
            tlq_pkg::S_EXEC: begin
                n_valid  = (r_op == tlq_pkg::OP_PUSH) || !(r_parent ? !pempty
                                                        : (r_is_child && !cempty));
                n_evout  = '0;
                n_nt     = 1'b0;
                if (r_op == tlq_pkg::OP_PUSH) begin
                    if (r_parent && !pfull) begin
                        pram_we  = 1'b1;
                        n_pfill  = r_pfill + PFW'(1);
                        n_status = tlq_pkg::ST_OK;
                    end else if (r_is_child && !pfull && !cfull) begin
                        pram_we     = 1'b1;
                        pram_wdata  = {1'b1, EVENT_WIDTH'(r_cidx)};
                        cram_we     = 1'b1;
                        n_pfill     = r_pfill + PFW'(1);
                        n_cfill_sel = cfill_sel + CFW'(1);
                        n_status    = tlq_pkg::ST_OK;
                        n_nt        = r_notify_en;
                    end else begin
                        n_status = tlq_pkg::ST_FULL;
                    end
                end else begin
                    n_status = tlq_pkg::ST_EMPTY;
                    if (r_is_child && !cempty) begin
                        n_chead_sel = chead_inc;
                        n_cfill_sel = cfill_sel - CFW'(1);
                    end
                end
            end
            tlq_pkg::S_PRD: begin
                n_phead = phead_inc;
                n_pfill = r_pfill - PFW'(1);
                if (!pram_rdata[EVENT_WIDTH]) begin
                    n_valid  = 1'b1;
                    n_status = tlq_pkg::ST_OK;
                    n_evout  = pram_rdata[EVENT_WIDTH-1:0];
                end else begin
                    n_cidx = pram_rdata[CIW-1:0];
                end
            end
            tlq_pkg::S_LINK: begin
                if (cempty) begin
                    // stale link: nothing to hand out
                    n_valid  = 1'b1;
                    n_status = tlq_pkg::ST_OK;
                    n_evout  = '0;
                end else begin
                    n_chead_sel = chead_inc;
                    n_cfill_sel = cfill_sel - CFW'(1);
                end
            end
            tlq_pkg::S_LRD: begin
                n_valid  = 1'b1;
                n_status = tlq_pkg::ST_OK;
                n_evout  = cram_rdata;
            end
            tlq_pkg::S_CRD: begin
                n_ev = cram_rdata;
                n_k  = '0;
            end
            tlq_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_valid  = 1'b1;
                    n_status = tlq_pkg::ST_OK;
                    n_evout  = r_ev;
                end
            end
            tlq_pkg::S_CHK: begin
                if (link_match) begin
                    if (r_k == '0) begin
                        n_phead  = phead_inc;
                        n_pfill  = r_pfill - PFW'(1);
                        n_valid  = 1'b1;
                        n_status = tlq_pkg::ST_OK;
                        n_evout  = r_ev;
                    end
                end else begin
                    n_k = r_k + PFW'(1);
                end
            end
            tlq_pkg::S_SHR: begin
                if (!more_after) begin
                    n_pfill  = r_pfill - PFW'(1);
                    n_valid  = 1'b1;
                    n_status = tlq_pkg::ST_OK;
                    n_evout  = r_ev;
                end
            end
            tlq_pkg::S_SHW: begin
                // close up: entry k takes entry k+1
                pram_we    = 1'b1;
                pram_wdata = pram_rdata;
                n_k        = r_k + PFW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlq_pkg::S_IDLE;
            r_phead     <= '0;
            r_pfill     <= '0;
            r_notify_en <= 1'b0;
            r_valid     <= 1'b0;
            for (int i = 0; i < NUM_CHILDREN; i++) begin
                r_chead[i] <= '0;
                r_cfill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_phead <= n_phead;
            r_pfill <= n_pfill;
            r_valid <= n_valid;
            r_chead[r_cidx] <= n_chead_sel;
            r_cfill[r_cidx] <= n_cfill_sel;
            if (i_cfg_valid) begin
                r_notify_en <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_parent   <= n_parent;
        r_is_child <= n_is_child;
        r_cidx     <= n_cidx;
        r_data     <= n_data;
        r_k        <= n_k;
        r_ev       <= n_ev;
        r_status   <= n_status;
        r_evout    <= n_evout;
        r_nt       <= n_nt;
    end

    tlq_ram #(
        .WIDTH (EW),
        .DEPTH (PARENT_DEPTH)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (pram_we),
        .i_waddr (p_slot),
        .i_wdata (pram_wdata),
        .i_raddr (p_slot),
        .o_rdata (pram_rdata)
    );

    tlq_ram #(
        .WIDTH (EVENT_WIDTH),
        .DEPTH (CMD)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (cram_we),
        .i_waddr (cram_addr),
        .i_wdata (r_data),
        .i_raddr (cram_addr),
        .o_rdata (cram_rdata)
    );

    assign o_busy         = (r_state != tlq_pkg::S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_event_out    = 32'(r_evout);
    assign o_notify       = r_nt;

    `TLQ_ASSERT_NOW(a_result_ends_work, o_result_valid, $past(o_busy),
        "result beat without a preceding busy item")
    `TLQ_ASSERT_NEXT(a_start_goes_busy, i_start && !o_busy, o_busy,
        "accepted item did not raise busy")
    `TLQ_ASSERT_NOW(a_fill_bound, 1'b1, r_pfill <= PFW'(PARENT_DEPTH),
        "parent fill beyond depth")
    `TLQ_ASSERT_NOW(a_notify_ok, o_result_valid && o_notify,
        o_status == tlq_pkg::ST_OK && o_event_out == '0,
        "notify on a beat that is not an accepted push")

endmodule

@@ tb/two_level_event_queue_unit_test.sv @@
// Self-checking testbench for two_level_event_queue_unit: a directed table, then random
// push/pop traffic with notify enable changes, all checked against an in-bench queue model.
// Depends on tlq_pkg and the two_level_event_queue_unit RTL.
module two_level_event_queue_unit_test;

    localparam int NCH = 4;
    localparam int CDEP = 16;
    localparam int PDEP = 64;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ev;
        logic        notify;
    } t_outcome;

    typedef struct packed {
        logic        op;
        logic [2:0]  sel;
        logic [31:0] data;
        logic        fixed;
        t_outcome    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_operation = tlq_pkg::OP_PUSH;
    logic [2:0]  i_queue_select = tlq_pkg::SEL_PARENT;
    logic [31:0] i_event_data = '0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        o_busy, o_result_valid, o_notify, o_cfg_ready;
    logic [1:0]  o_status;
    logic [31:0] o_event_out;

    two_level_event_queue_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // queue model: child FIFOs plus parent order (bit 32 set = link to child)
    logic [31:0] child_q[NCH][$];
    logic [32:0] order_q[$];
    logic        notify_on = 1'b0;
    t_outcome    pending[$];
    int          errors = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          send_gap = 0;
    longint      cycles = 0;

    function automatic t_outcome predict_queue_op(logic op, logic [2:0] sel, logic [31:0] d);
        t_outcome r;
        int c;
        logic [32:0] e;
        r = '{status: tlq_pkg::ST_OK, ev: '0, notify: 1'b0};
        c = int'(sel) - 1;
        if (op == tlq_pkg::OP_PUSH) begin
            if (sel == tlq_pkg::SEL_PARENT) begin
                if (order_q.size() >= PDEP) r.status = tlq_pkg::ST_FULL;
                else order_q.push_back({1'b0, d});
            end else if (c < NCH) begin
                if (child_q[c].size() >= CDEP || order_q.size() >= PDEP)
                    r.status = tlq_pkg::ST_FULL;
                else begin
                    child_q[c].push_back(d);
                    order_q.push_back({1'b1, 32'(c)});
                    r.notify = notify_on;
                end
            end else r.status = tlq_pkg::ST_FULL;
        end else begin
            if (sel == tlq_pkg::SEL_PARENT) begin
                if (order_q.size() == 0) r.status = tlq_pkg::ST_EMPTY;
                else begin
                    e = order_q.pop_front();
                    if (e[32]) begin
                        if (child_q[e[15:0]].size() > 0) r.ev = child_q[e[15:0]].pop_front();
                    end else r.ev = e[31:0];
                end
            end else if (c < NCH) begin
                if (child_q[c].size() == 0) r.status = tlq_pkg::ST_EMPTY;
                else begin
                    r.ev = child_q[c].pop_front();
                    foreach (order_q[k])
                        if (order_q[k][32] && order_q[k][15:0] == c) begin
                            order_q.delete(k);
                            break;
                        end
                end
            end else r.status = tlq_pkg::ST_EMPTY;
        end
        return r;
    endfunction

    // drive on the edge after the previous beat; busy is still high then
    task automatic send_request(logic op, logic [2:0] sel, logic [31:0] d,
                                logic fixed, t_outcome want);
        t_outcome p;
        @(posedge i_clk);
        while (send_gap > 0 && $urandom_range(99) < send_gap) @(posedge i_clk);
        i_start <= 1'b1;
        i_operation <= op;
        i_queue_select <= sel;
        i_event_data <= d;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        p = predict_queue_op(op, sel, d);
        if (fixed && p != want) begin
            errors++;
            $display("%0t table row disagrees: want %h model %h", $time, want, p);
        end
        pending.push_back(p);
        n_items++;
        i_start <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_notify(logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        notify_on = v;
        i_cfg_valid <= 1'b0;
    endtask

    // results are sampled at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        t_outcome w;
        cycles++;
        if (i_rst_n && o_result_valid) begin
            n_results++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result %h/%h/%b", $time, o_status, o_event_out, o_notify);
            end else begin
                w = pending.pop_front();
                if (o_status !== w.status || o_event_out !== w.ev || o_notify !== w.notify) begin
                    errors++;
                    $display("%0t mismatch: expected st=%0d ev=%h nt=%b, actual st=%0d ev=%h nt=%b",
                             $time, w.status, w.ev, w.notify, o_status, o_event_out, o_notify);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("two_level_event_queue_unit_test NOT OK");
            $finish;
        end
    end

    t_row table_rows[] = '{
        '{tlq_pkg::OP_POP,  3'd0, 32'h0,        1'b1, '{tlq_pkg::ST_EMPTY, 32'h0, 1'b0}},
        '{tlq_pkg::OP_POP,  3'd1, 32'hFFFFFFFF, 1'b1, '{tlq_pkg::ST_EMPTY, 32'h0, 1'b0}},
        '{tlq_pkg::OP_POP,  3'd5, 32'h0,        1'b1, '{tlq_pkg::ST_EMPTY, 32'h0, 1'b0}},
        '{tlq_pkg::OP_POP,  3'd7, 32'h0,        1'b1, '{tlq_pkg::ST_EMPTY, 32'h0, 1'b0}},
        '{tlq_pkg::OP_PUSH, 3'd6, 32'h1234,     1'b1, '{tlq_pkg::ST_FULL,  32'h0, 1'b0}},
        '{tlq_pkg::OP_PUSH, 3'd7, 32'hFFFFFFFF, 1'b1, '{tlq_pkg::ST_FULL,  32'h0, 1'b0}},
        '{tlq_pkg::OP_PUSH, 3'd0, 32'hFFFFFFFF, 1'b1, '{tlq_pkg::ST_OK,    32'h0, 1'b0}},
        '{tlq_pkg::OP_PUSH, 3'd0, 32'h0,        1'b1, '{tlq_pkg::ST_OK,    32'h0, 1'b0}},
        '{tlq_pkg::OP_PUSH, 3'd1, 32'hA5A5A5A5, 1'b0, '0},
        '{tlq_pkg::OP_PUSH, 3'd4, 32'h5A5A5A5A, 1'b0, '0},
        '{tlq_pkg::OP_PUSH, 3'd2, 32'h00000001, 1'b0, '0},
        '{tlq_pkg::OP_PUSH, 3'd4, 32'h80000000, 1'b0, '0},
        '{tlq_pkg::OP_POP,  3'd4, 32'h0,        1'b0, '0},
        '{tlq_pkg::OP_POP,  3'd0, 32'h0,        1'b1, '{tlq_pkg::ST_OK, 32'hFFFFFFFF, 1'b0}},
        '{tlq_pkg::OP_POP,  3'd0, 32'h0,        1'b1, '{tlq_pkg::ST_OK, 32'h0, 1'b0}},
        '{tlq_pkg::OP_POP,  3'd0, 32'h0,        1'b0, '0},
        '{tlq_pkg::OP_POP,  3'd0, 32'h0,        1'b0, '0},
        '{tlq_pkg::OP_POP,  3'd0, 32'h0,        1'b0, '0},
        '{tlq_pkg::OP_POP,  3'd0, 32'h0,        1'b1, '{tlq_pkg::ST_EMPTY, 32'h0, 1'b0}},
        '{tlq_pkg::OP_POP,  3'd3, 32'h0,        1'b1, '{tlq_pkg::ST_EMPTY, 32'h0, 1'b0}}
    };

    initial begin
        int phase;
        int fill_bias;
        logic op;
        logic [2:0] sel;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i])
            send_request(table_rows[i].op, table_rows[i].sel, table_rows[i].data,
                         table_rows[i].fixed, table_rows[i].want);
        drain_results();
        write_notify(1'b1);

        // fill every child then the parent to the top, so both full cases show up
        for (int c = 1; c <= NCH; c++)
            for (int k = 0; k < CDEP + 1; k++)
                send_request(tlq_pkg::OP_PUSH, 3'(c), $urandom, 1'b0, '0);
        repeat (2) send_request(tlq_pkg::OP_PUSH, tlq_pkg::SEL_PARENT, $urandom, 1'b0, '0);
        send_request(tlq_pkg::OP_POP, 3'd2, 32'h0, 1'b0, '0);
        send_request(tlq_pkg::OP_POP, 3'd3, 32'h0, 1'b0, '0);
        repeat (PDEP + 2)
            send_request(tlq_pkg::OP_POP, tlq_pkg::SEL_PARENT, $urandom, 1'b0, '0);
        drain_results();

        for (phase = 0; phase < 3; phase++) begin
            send_gap = (phase == 0) ? 22 : (phase == 1) ? 52 : 0;
            write_notify(phase != 1);
            for (int n = 0; n < 600; n++) begin
                // push-heavy and pop-heavy stretches sweep the fill levels
                fill_bias = ((n / 100) % 2 == 0) ? 70 : 30;
                op = ($urandom_range(99) < fill_bias) ? tlq_pkg::OP_PUSH : tlq_pkg::OP_POP;
                sel = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                                : 3'($urandom_range(NCH));
                send_request(op, sel, $urandom, 1'b0, '0);
                if (n == 300) drain_results();
            end
            drain_results();
        end

        $display("Ran %0d requests, %0d results checked, over three idle settings",
                 n_items, n_results);
        $display("with notify toggled, full and empty queues, and invalid selects.");
        if (errors == 0) begin
            $display("two_level_event_queue_unit_test OK");
        end else begin
            $display("two_level_event_queue_unit_test NOT OK");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/tlq_pkg.sv
hdl/tlq_ram.sv
hdl/two_level_event_queue_unit.sv
tb/two_level_event_queue_unit_test.sv
